// ===== design/systematic_resampler_macros.svh =====
// ----------------------------------------------------------------------------
// Systematic resampler assertion macros
// Shared property forms for the checker that watches the resampler's ports.
// ----------------------------------------------------------------------------
`ifndef SYSTEMATIC_RESAMPLER_MACROS_SVH
`define SYSTEMATIC_RESAMPLER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SR_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("systematic_resampler: port check failed");

// Consequent must hold in the cycle after the antecedent.
`define SR_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("systematic_resampler: port check failed");

`endif

// ===== design/sysres_pkg.sv =====
// ----------------------------------------------------------------------------
// Systematic resampler package
// Payload structs, command codes and the control/status bundles shared by
// the controller and the datapath.
// ----------------------------------------------------------------------------
package sysres_pkg;

   localparam int WEIGHT_W = 32;
   localparam int FRAC_W   = 16;
   localparam int TOTAL_W  = 40;
   localparam int PCOUNT_W = 9;
   localparam int INDEX_W  = 8;
   localparam int COUNT_W  = 9;

   localparam logic [PCOUNT_W-1:0] PCOUNT_RESET = 9'd200;

   typedef enum logic [1:0] {
      CMD_LOAD  = 2'd0,
      CMD_START = 2'd1,
      CMD_VISIT = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      CNT_ZERO = 2'd0,
      CNT_OWED = 2'd1,
      CNT_QUOT = 2'd2
   } cnt_src_type;

   typedef struct packed {
      logic [1:0]          cmd;
      logic [WEIGHT_W-1:0] weight;
      logic [FRAC_W-1:0]   random_fraction;
   } req_type;

   typedef struct packed {
      logic [INDEX_W-1:0] particle_index;
      logic [COUNT_W-1:0] copy_count;
      logic               last_particle;
      logic               error_flag;
   } rsp_type;

   typedef struct packed {
      logic        load_weight;
      logic        start;
      logic        err_load;
      logic        div_start;
      logic        div_visit;
      logic        step_load;
      logic        pointer_init;
      logic        p_load;
      logic        cnt_load;
      cnt_src_type cnt_src;
      logic        prod_load;
      logic        commit;
      logic        rsp_load;
   } ctl_type;

   typedef struct packed {
      logic visit_over;
      logic p_pos;
      logic step_zero;
      logic last;
      logic div_done;
   } sta_type;

endpackage

// ===== design/sysres_div.sv =====
// ----------------------------------------------------------------------------
// Systematic resampler divider
// Restoring unsigned divider, one quotient bit per cycle, with a one-cycle
// done pulse once the last bit is in.
// ----------------------------------------------------------------------------
module sysres_div #(
   parameter int DW = 43,
   parameter int SW = 40
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [SW-1:0] divisor,
   output logic          done,
   output logic [DW-1:0] quotient
);

   localparam int CW = $clog2(DW + 1);

   logic [CW-1:0] cnt_ff, cnt_in;
   logic          active_ff, active_in;
   logic          done_ff, done_in;
   logic [SW-1:0] rem_ff, rem_in;
   logic [SW-1:0] dsr_ff, dsr_in;
   logic [DW-1:0] quo_ff, quo_in;
   logic [SW:0]   trial;
   logic [SW:0]   diff;

   always_comb begin
      trial     = {rem_ff, quo_ff[DW-1]};
      diff      = trial - {1'b0, dsr_ff};
      cnt_in    = cnt_ff;
      active_in = active_ff;
      done_in   = 1'b0;
      rem_in    = rem_ff;
      dsr_in    = dsr_ff;
      quo_in    = quo_ff;
      if (start) begin
         rem_in    = '0;
         quo_in    = dividend;
         dsr_in    = divisor;
         cnt_in    = CW'(DW);
         active_in = 1'b1;
      end else if (active_ff) begin
         // The remainder stays below the divisor, so the top bit of the
         // difference tells whether the trial subtraction fits.
         if (!diff[SW]) begin
            rem_in = diff[SW-1:0];
            quo_in = {quo_ff[DW-2:0], 1'b1};
         end else begin
            rem_in = trial[SW-1:0];
            quo_in = {quo_ff[DW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= '0;
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         cnt_ff    <= cnt_in;
         active_ff <= active_in;
         done_ff   <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== design/sysres_dpath.sv =====
// ----------------------------------------------------------------------------
// Systematic resampler datapath
// Weight memory, running total, step and pointer registers, copy count
// arithmetic and the result registers, driven by the controller's commands.
// ----------------------------------------------------------------------------
module sysres_dpath import sysres_pkg::*; #(
   parameter int MAX_PARTICLES = 256
) (
   input  logic                clock,
   input  logic                reset,
   input  req_type             req_data,
   input  logic                csr_valid,
   input  logic [PCOUNT_W-1:0] csr_data,
   input  ctl_type             ctl,
   output sta_type             sta,
   output rsp_type             rsp_data
);

   localparam int NW = $clog2(MAX_PARTICLES + 1);
   localparam int AW = $clog2(MAX_PARTICLES);
   // Pointer range: a full generation of weights below zero, plus the total.
   localparam int PW = (NW + 34 > 42) ? NW + 34 : 42;

   logic [WEIGHT_W-1:0] weight_mem [MAX_PARTICLES];
   logic [WEIGHT_W-1:0] rd_data_ff;

   logic [PCOUNT_W-1:0] csr_ff;
   logic [TOTAL_W-1:0]  total_ff, total_in;
   logic [TOTAL_W:0]    total_sum;
   logic [TOTAL_W-1:0]  step_ff;
   logic signed [PW-1:0] pointer_ff;
   logic [NW-1:0]       load_ff, visit_ff, emitted_ff;
   logic [FRAC_W-1:0]   frac_ff;
   logic signed [PW-1:0] p_ff;
   logic [NW-1:0]       count_ff, count_in;
   logic [PW-1:0]       prod_ff;
   rsp_type             res_ff;
   rsp_type             rsp_ff;

   logic [NW-1:0]              n_eff;
   logic [NW-1:0]              owed;
   logic                       load_ok;
   logic [PW-1:0]              div_dividend;
   logic [TOTAL_W-1:0]         div_divisor;
   logic [PW-1:0]              quo;
   logic                       div_done;
   logic [TOTAL_W+FRAC_W-1:0]  frac_prod;
   logic [TOTAL_W+NW-1:0]      cnt_prod;
   logic                       last;

   always_comb begin
      if (csr_ff == '0) begin
         n_eff = NW'(1);
      end else if (32'(csr_ff) > MAX_PARTICLES) begin
         n_eff = NW'(MAX_PARTICLES);
      end else begin
         n_eff = NW'(csr_ff);
      end
   end

   assign owed      = (emitted_ff < n_eff) ? (n_eff - emitted_ff) : '0;
   assign last      = ({1'b0, visit_ff} + (NW + 1)'(1)) == {1'b0, n_eff};
   assign load_ok   = load_ff < NW'(MAX_PARTICLES);
   assign total_sum = {1'b0, total_ff} + (TOTAL_W + 1)'(req_data.weight);
   assign total_in  = total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];

   assign div_dividend = ctl.div_visit ? $unsigned(-p_ff) : PW'(total_ff);
   assign div_divisor  = ctl.div_visit ? step_ff : TOTAL_W'(n_eff);

   sysres_div #(
      .DW (PW),
      .SW (TOTAL_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (ctl.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (quo)
   );

   assign frac_prod = (TOTAL_W + FRAC_W)'(frac_ff) * (TOTAL_W + FRAC_W)'(step_ff);
   assign cnt_prod  = (TOTAL_W + NW)'(count_ff) * (TOTAL_W + NW)'(step_ff);

   always_comb begin
      unique case (ctl.cnt_src)
         CNT_ZERO: count_in = '0;
         CNT_OWED: count_in = owed;
         CNT_QUOT: begin
            // Count is quotient plus one, capped at the copies still owed.
            if (quo >= PW'(owed)) begin
               count_in = owed;
            end else begin
               count_in = quo[NW-1:0] + NW'(1);
            end
         end
         default: count_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctl.load_weight && load_ok) begin
         weight_mem[load_ff[AW-1:0]] <= req_data.weight;
      end
      rd_data_ff <= weight_mem[visit_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff     <= PCOUNT_RESET;
         total_ff   <= '0;
         step_ff    <= '0;
         pointer_ff <= '0;
         load_ff    <= '0;
         visit_ff   <= '0;
         emitted_ff <= '0;
      end else begin
         if (csr_valid) begin
            csr_ff <= csr_data;
         end
         if (ctl.load_weight && load_ok) begin
            total_ff <= total_in;
            load_ff  <= load_ff + NW'(1);
         end
         if (ctl.start) begin
            total_ff   <= '0;
            load_ff    <= '0;
            visit_ff   <= '0;
            emitted_ff <= '0;
         end
         if (ctl.step_load) begin
            step_ff <= quo[TOTAL_W-1:0];
         end
         if (ctl.pointer_init) begin
            pointer_ff <= $signed(PW'(frac_prod[TOTAL_W+FRAC_W-1:FRAC_W]));
         end
         if (ctl.commit) begin
            pointer_ff <= p_ff + $signed(prod_ff);
            emitted_ff <= emitted_ff + count_ff;
            visit_ff   <= visit_ff + NW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.start) begin
         frac_ff <= req_data.random_fraction;
      end
      if (ctl.p_load) begin
         p_ff <= pointer_ff - $signed({{(PW - WEIGHT_W){1'b0}}, rd_data_ff});
      end
      if (ctl.cnt_load) begin
         count_ff <= count_in;
      end
      if (ctl.prod_load) begin
         prod_ff <= PW'(cnt_prod);
      end
      if (ctl.err_load) begin
         res_ff.particle_index <= '0;
         res_ff.copy_count     <= '0;
         res_ff.last_particle  <= 1'b0;
         res_ff.error_flag     <= 1'b1;
      end else if (ctl.commit) begin
         res_ff.particle_index <= INDEX_W'(visit_ff);
         res_ff.copy_count     <= COUNT_W'(count_ff);
         res_ff.last_particle  <= last;
         res_ff.error_flag     <= 1'b0;
      end
      if (ctl.rsp_load) begin
         rsp_ff <= res_ff;
      end
   end

   assign sta.visit_over = visit_ff >= n_eff;
   assign sta.p_pos      = !p_ff[PW-1] && (p_ff != '0);
   assign sta.step_zero  = step_ff == '0;
   assign sta.last       = last;
   assign sta.div_done   = div_done;
   assign rsp_data       = rsp_ff;

endmodule

// ===== design/sysres_ctrl.sv =====
// ----------------------------------------------------------------------------
// Systematic resampler controller
// Sequences loads, the start division and pointer set-up, and the visit
// steps; owns the request ready and the result valid.
// ----------------------------------------------------------------------------
module sysres_ctrl import sysres_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_cmd,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  sta_type    sta,
   output ctl_type    ctl
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_STEP_DIV,
      S_POINT,
      S_SUB,
      S_DECIDE,
      S_CNT_DIV,
      S_MUL,
      S_ADD,
      S_OUT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      ctl       = '0;
      state_in  = state_ff;
      req_ready = (state_ff == S_IDLE);
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               unique case (req_cmd)
                  CMD_LOAD: ctl.load_weight = 1'b1;
                  CMD_START: begin
                     ctl.start     = 1'b1;
                     ctl.div_start = 1'b1;
                     state_in      = S_STEP_DIV;
                  end
                  CMD_VISIT: begin
                     if (sta.visit_over) begin
                        ctl.err_load = 1'b1;
                        state_in     = S_OUT;
                     end else begin
                        state_in = S_SUB;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_STEP_DIV: begin
            if (sta.div_done) begin
               ctl.step_load = 1'b1;
               state_in      = S_POINT;
            end
         end
         S_POINT: begin
            ctl.pointer_init = 1'b1;
            state_in         = S_IDLE;
         end
         S_SUB: begin
            ctl.p_load = 1'b1;
            state_in   = S_DECIDE;
         end
         S_DECIDE: begin
            // A pointer still above zero takes no copies unless this is the
            // final particle; with no step, or on the final particle, every
            // owed copy goes to this one.
            priority if (sta.p_pos && !sta.last) begin
               ctl.cnt_load = 1'b1;
               ctl.cnt_src  = CNT_ZERO;
               state_in     = S_MUL;
            end else if (sta.step_zero || sta.last) begin
               ctl.cnt_load = 1'b1;
               ctl.cnt_src  = CNT_OWED;
               state_in     = S_MUL;
            end else begin
               ctl.div_start = 1'b1;
               ctl.div_visit = 1'b1;
               state_in      = S_CNT_DIV;
            end
         end
         S_CNT_DIV: begin
            if (sta.div_done) begin
               ctl.cnt_load = 1'b1;
               ctl.cnt_src  = CNT_QUOT;
               state_in     = S_MUL;
            end
         end
         S_MUL: begin
            ctl.prod_load = 1'b1;
            state_in      = S_ADD;
         end
         S_ADD: begin
            ctl.commit = 1'b1;
            state_in   = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               ctl.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      rsp_valid_in = ctl.rsp_load || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== design/systematic_resampler.sv =====
// ----------------------------------------------------------------------------
// Systematic resampler
// Particle filter systematic resampling: stores weights, derives the step
// from their total, and reports the copy count of each visited particle.
//
//   Channel   Handshake               Carries
//   req       req_valid / req_ready   cmd, weight, random_fraction
//   rsp       rsp_valid / rsp_ready   particle_index, copy_count, flags
//   csr       csr_valid / csr_ready   particle_count
//
// Start requests, and visits that need a division, wait on the bit-serial
// divider, PW = max(42, NW + 34) bits wide with NW = clog2(MAX_PARTICLES + 1);
// a visit that needs no division skips it, and a load request does not use it.
// Reset is synchronous and needs no clearing pass. A result waiting on
// rsp_ready holds its output register while the next request is accepted.
// ----------------------------------------------------------------------------
module systematic_resampler import sysres_pkg::*; #(
   parameter int MAX_PARTICLES = 256
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  req_type             req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output rsp_type             rsp_data,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [PCOUNT_W-1:0] csr_data
);

   ctl_type ctl;
   sta_type sta;

   assign csr_ready = 1'b1;

   sysres_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_cmd   (req_data.cmd),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sta       (sta),
      .ctl       (ctl)
   );

   sysres_dpath #(
      .MAX_PARTICLES (MAX_PARTICLES)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .ctl       (ctl),
      .sta       (sta),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== design/sysres_chk.sv =====
// ----------------------------------------------------------------------------
// Systematic resampler checker
// Port-level assertions on the result register, request sequencing and the
// configuration port, bound to the top level.
// ----------------------------------------------------------------------------
`include "systematic_resampler_macros.svh"

module sysres_chk import sysres_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input req_type             req_data,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input rsp_type             rsp_data,
   input logic                csr_valid,
   input logic                csr_ready
);

   logic req_fire;
   logic long_cmd;
   logic rsp_stall;
   logic err_clean;

   assign req_fire  = req_valid && req_ready;
   assign long_cmd  = (req_data.cmd == CMD_START) || (req_data.cmd == CMD_VISIT);
   assign rsp_stall = rsp_valid && !rsp_ready;
   assign err_clean = (rsp_data.copy_count == '0) && (rsp_data.particle_index == '0) &&
                      !rsp_data.last_particle;

   // A stalled result must hold.
   `SR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_data))

   // An error result carries nothing else.
   `SR_ASSERT_IMPLY(a_err_clean, clock, reset, rsp_valid && rsp_data.error_flag, err_clean)

   // A start or visit request, once accepted, takes the block out of its ready state.
   `SR_ASSERT_NEXT(a_busy_after, clock, reset, req_fire && long_cmd, !req_ready)

   // The configuration port never stalls.
   `SR_ASSERT_IMPLY(a_csr_ready, clock, reset, csr_valid, csr_ready)

endmodule

bind systematic_resampler sysres_chk u_sysres_chk (.*);
